FILE: rtl/des_ks_pkg.sv
`timescale 1ns / 1ps

package des_ks_pkg;

  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned HALF_BITS   = 28;
  localparam int unsigned CD_BITS     = 2 * HALF_BITS;
  localparam int unsigned SUBKEY_BITS = 48;
  localparam int unsigned ROUNDS      = 16;
  localparam int unsigned ROUND_BITS  = 4;

  localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(ROUNDS - 1);

  typedef logic [HALF_BITS-1:0]   half_t;
  typedef logic [CD_BITS-1:0]     cd_t;
  typedef logic [SUBKEY_BITS-1:0] subkey_t;
  typedef logic [ROUND_BITS-1:0]  round_t;

  // Bit positions are numbered from 1 at the most significant end.
  localparam logic [6:0] PC1_TAB [CD_BITS] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
    7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
    7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
    7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
    7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [SUBKEY_BITS] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
    6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
    6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] SHIFT_TAB [ROUNDS] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  function automatic cd_t pc1(input logic [KEY_BITS-1:0] key);
    cd_t cd;
    cd = '0;
    for (int i = 0; i < CD_BITS; i++) begin
      cd[CD_BITS-1-i] = key[6'(KEY_BITS - PC1_TAB[i])];
    end
    return cd;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t sk;
    sk = '0;
    for (int i = 0; i < SUBKEY_BITS; i++) begin
      sk[SUBKEY_BITS-1-i] = cd[6'(CD_BITS - PC2_TAB[i])];
    end
    return sk;
  endfunction

  function automatic half_t rotl(input half_t v, input logic [1:0] n);
    half_t r;
    if (n == 2'd2) begin
      r = {v[HALF_BITS-3:0], v[HALF_BITS-1:HALF_BITS-2]};
    end else begin
      r = {v[HALF_BITS-2:0], v[HALF_BITS-1]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/des_ks_front.sv
`timescale 1ns / 1ps

// Accepts keys and registers the key-permuted halves.
module des_ks_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         key,
  input  logic                key_valid,
  output logic                key_ready,
  output des_ks_pkg::cd_t     cd,
  output logic                cd_valid,
  input  logic                cd_ready
);

  logic v;

  assign key_ready = !v || cd_ready;
  assign cd_valid  = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (key_valid && key_ready) begin
      v <= 1'b1;
    end else if (cd_ready) begin
      v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && key_ready) begin
      cd <= des_ks_pkg::pc1(key);
    end
  end

endmodule

FILE: rtl/des_ks_fifo.sv
`timescale 1ns / 1ps

// Short queue of permuted halves between front and back.
module des_ks_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  des_ks_pkg::cd_t wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output des_ks_pkg::cd_t rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  des_ks_pkg::cd_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/des_ks_back.sv
`timescale 1ns / 1ps

// Round sequencer: one rotation and compression permutation per cycle
// while the output is not stalled, result held in an output register.
module des_ks_back (
  input  logic                clk,
  input  logic                rst,
  input  des_ks_pkg::cd_t     cd,
  input  logic                cd_valid,
  output logic                cd_ready,
  output logic [47:0]         subkey,
  output logic [3:0]          round_index,
  output logic                last,
  output logic                subkey_valid,
  input  logic                subkey_ready
);

  des_ks_pkg::half_t  c;
  des_ks_pkg::half_t  d;
  des_ks_pkg::half_t  c_next;
  des_ks_pkg::half_t  d_next;
  des_ks_pkg::round_t rnd;
  logic               active;
  logic               step;
  logic               load;

  assign step     = active && (!subkey_valid || subkey_ready);
  assign cd_ready = !active || (step && rnd == des_ks_pkg::LAST_ROUND);
  assign load     = cd_valid && cd_ready;

  assign c_next = des_ks_pkg::rotl(c, des_ks_pkg::SHIFT_TAB[rnd]);
  assign d_next = des_ks_pkg::rotl(d, des_ks_pkg::SHIFT_TAB[rnd]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      rnd          <= '0;
      subkey_valid <= 1'b0;
    end else begin
      if (step) begin
        subkey_valid <= 1'b1;
      end else if (subkey_ready) begin
        subkey_valid <= 1'b0;
      end
      // a new key loads on the same edge as the previous key's final round
      if (load) begin
        active <= 1'b1;
        rnd    <= '0;
      end else if (step) begin
        rnd <= rnd + 1'b1;
        if (rnd == des_ks_pkg::LAST_ROUND) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c <= cd[des_ks_pkg::CD_BITS-1:des_ks_pkg::HALF_BITS];
      d <= cd[des_ks_pkg::HALF_BITS-1:0];
    end else if (step) begin
      c <= c_next;
      d <= d_next;
    end
    if (step) begin
      subkey      <= des_ks_pkg::pc2({c_next, d_next});
      round_index <= rnd;
      last        <= rnd == des_ks_pkg::LAST_ROUND;
    end
  end

endmodule

FILE: rtl/des_key_schedule.sv
`timescale 1ns / 1ps

// DES key schedule. Each key item yields sixteen subkey items, rounds 0
// through 15 in order, with last set on the final round. The front takes
// a key whenever its register or the queue behind it has room and applies
// the key permutation that drops the parity bits; the back pulls halves
// from the queue and, while the subkey side is not stalled, runs one round
// per cycle (rotate both halves, then the compression permutation) into an
// output register, and the next key's first round follows the previous
// key's last round with no gap. From an empty pipe, an accepted key passes
// the front register, the queue, the back's half registers and the output
// register before its first subkey appears. Up to QUEUE_DEPTH + 1 keys can
// be taken ahead of the key in progress, so the key side stalls only once
// all of those slots are full while the subkey side waits.
module des_key_schedule #(
  parameter int unsigned QUEUE_DEPTH = 2  // keys buffered, 1 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] key,
  input  logic        key_valid,
  output logic        key_ready,
  output logic [47:0] subkey,
  output logic [3:0]  round_index,
  output logic        last,
  output logic        subkey_valid,
  input  logic        subkey_ready
);

  // front -> queue
  des_ks_pkg::cd_t f_cd;
  logic            f_valid;
  logic            f_ready;
  // queue -> back
  des_ks_pkg::cd_t q_cd;
  logic            q_valid;
  logic            q_ready;

  des_ks_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .cd        (f_cd),
    .cd_valid  (f_valid),
    .cd_ready  (f_ready)
  );

  des_ks_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_cd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_cd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  des_ks_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cd           (q_cd),
    .cd_valid     (q_valid),
    .cd_ready     (q_ready),
    .subkey       (subkey),
    .round_index  (round_index),
    .last         (last),
    .subkey_valid (subkey_valid),
    .subkey_ready (subkey_ready)
  );

endmodule
